>>> rtl/hatfr_pkg.sv
// Package for the hex and text frame receiver.
// Holds sizes, byte codes, register indexes, reset values and the
// controller/datapath interface structs; it depends on nothing else.
`timescale 1ns / 1ps

package hatfr_pkg;

  localparam int PAYLOAD_MAX   = 32;
  localparam int CAPTURE_BYTES = 36;
  localparam int LINE_BYTES    = 64;

  localparam int DATA_W     = 8;
  localparam int LEN_W      = 6;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int CAP_AW  = $clog2(CAPTURE_BYTES);
  localparam int CAP_CW  = $clog2(CAPTURE_BYTES + 1);
  localparam int LINE_AW = $clog2(LINE_BYTES);

  localparam logic [DATA_W-1:0] CH_CR = 8'd13;
  localparam logic [DATA_W-1:0] CH_LF = 8'd10;

  localparam int FIXED_FRAME_BYTES = 5;
  localparam int EMPTY_FRAME_BYTES = 4;
  localparam int FRAME_OVERHEAD    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEAD   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TAIL   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_TOUT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_TOUT    = 8'd3;

  localparam logic [DATA_W-1:0] FRAME_HEAD_RST   = 8'd165;
  localparam logic [DATA_W-1:0] FRAME_TAIL_RST   = 8'd90;
  localparam logic [TICK_W-1:0] CAPTURE_TOUT_RST = 16'd50;
  localparam logic [TICK_W-1:0] LINE_TOUT_RST    = 16'd100;

  localparam logic [1:0] BASE_LINE  = 2'd0;
  localparam logic [1:0] BASE_FIXED = 2'd1;
  localparam logic [1:0] BASE_VAR   = 2'd2;

  localparam logic SRC_FRAME = 1'b0;
  localparam logic SRC_LINE  = 1'b1;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic last_item;
  } status_t;

endpackage

>>> rtl/hex_and_text_frame_receiver.sv
// Top level of the hex and text frame receiver.
// Instantiates hatfr_ctrl and hatfr_dpath; uses hatfr_pkg.
`timescale 1ns / 1ps

// After an input transfer that causes no result, the next item can be taken
// in the following cycle. A transfer that ends a frame or a line holds the
// input stalled while its burst of N result items is sent: each item passes
// through ST_READ for the registered store read and ST_SEND for loading the
// output register, and ST_SEND waits while the output is stalled. The last
// item may still wait in the output register while the next input transfer
// is taken. Configuration writes are always ready; indexes beyond the four
// registers are ignored.
module hex_and_text_frame_receiver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hatfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hatfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             in_kind_i,
  input  logic [hatfr_pkg::DATA_W-1:0]     in_rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_source_o,
  output logic [hatfr_pkg::DATA_W-1:0]     out_data_byte_o,
  output logic [hatfr_pkg::LEN_W-1:0]      out_burst_length_o,
  output logic                             out_empty_frame_o,
  output logic                             out_last_o
);
  import hatfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  hatfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hatfr_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_kind_i          (in_kind_i),
    .in_rx_byte_i       (in_rx_byte_i),
    .out_source_o       (out_source_o),
    .out_data_byte_o    (out_data_byte_o),
    .out_burst_length_o (out_burst_length_o),
    .out_empty_frame_o  (out_empty_frame_o),
    .out_last_o         (out_last_o),
    .cmd_i              (cmd),
    .status_o           (status)
  );

endmodule

>>> rtl/hatfr_ctrl.sv
// Controller state machine of the hex and text frame receiver.
// Sequences input transfers and burst output; uses hatfr_pkg.
`timescale 1ns / 1ps

module hatfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  hatfr_pkg::status_t status_i,
  output hatfr_pkg::cmd_t    cmd_o
);
  import hatfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   load;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign load   = (state_q == ST_SEND) && (!out_valid_q || !out_stall_i);

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.load   = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && status_i.emit) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (load) begin
            state_q <= status_i.last_item ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/hatfr_dpath.sv
// Datapath of the hex and text frame receiver: configuration registers,
// capture and line stores, frame checks, timeout counter and output register.
// Uses hatfr_pkg and is driven by hatfr_ctrl.
`timescale 1ns / 1ps

module hatfr_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [hatfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hatfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_kind_i,
  input  logic [hatfr_pkg::DATA_W-1:0]     in_rx_byte_i,
  output logic                           out_source_o,
  output logic [hatfr_pkg::DATA_W-1:0]     out_data_byte_o,
  output logic [hatfr_pkg::LEN_W-1:0]      out_burst_length_o,
  output logic                           out_empty_frame_o,
  output logic                           out_last_o,
  input  hatfr_pkg::cmd_t                 cmd_i,
  output hatfr_pkg::status_t              status_o
);
  import hatfr_pkg::*;

  logic [DATA_W-1:0] frame_head_q, frame_tail_q;
  logic [TICK_W-1:0] cap_tout_q, line_tout_q;

  logic              capturing_q, capturing_d;
  logic [CAP_CW-1:0] cap_cnt_q, cap_cnt_d;
  logic [LINE_AW-1:0] line_cnt_q, line_cnt_d;
  logic [TICK_W-1:0] idle_q, idle_d, idle_inc;
  logic [DATA_W-1:0] len_q, len_d, b2_q, b2_d, b3_q, b3_d, sum_q, sum_d, prev_q;

  logic [DATA_W-1:0] cap_mem [CAPTURE_BYTES];
  logic [DATA_W-1:0] line_mem [LINE_BYTES];
  logic [DATA_W-1:0] cap_rdata_q, line_rdata_q;
  logic              cap_we, line_we;
  logic [CAP_AW-1:0] cap_wa;
  logic [CAP_AW-1:0] cap_ra;

  logic              emit, emit_empty, emit_src;
  logic [1:0]        emit_base;
  logic [LEN_W-1:0]  emit_len;
  logic              src_q, empty_q;
  logic [1:0]        base_q;
  logic [LEN_W-1:0]  blen_q, idx_q;
  logic              last_item;

  logic [8:0] cnt9, ncnt9, len9;
  logic       is_tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_head_q <= FRAME_HEAD_RST;
      frame_tail_q <= FRAME_TAIL_RST;
      cap_tout_q   <= CAPTURE_TOUT_RST;
      line_tout_q  <= LINE_TOUT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_HEAD:   frame_head_q <= cfg_data_i[DATA_W-1:0];
        REG_FRAME_TAIL:   frame_tail_q <= cfg_data_i[DATA_W-1:0];
        REG_CAPTURE_TOUT: cap_tout_q   <= cfg_data_i;
        REG_LINE_TOUT:    line_tout_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cnt9     = 9'(cap_cnt_q);
  assign ncnt9    = 9'(cap_cnt_q) + 9'd1;
  assign len9     = 9'(len_q);
  assign is_tail  = (in_rx_byte_i == frame_tail_q);
  assign idle_inc = (idle_q == {TICK_W{1'b1}}) ? idle_q : idle_q + 1'b1;

  always_comb begin
    capturing_d = capturing_q;
    cap_cnt_d   = cap_cnt_q;
    line_cnt_d  = line_cnt_q;
    idle_d      = idle_q;
    len_d       = len_q;
    b2_d        = b2_q;
    b3_d        = b3_q;
    sum_d       = sum_q;
    cap_we      = 1'b0;
    cap_wa      = '0;
    line_we     = 1'b0;
    emit        = 1'b0;
    emit_empty  = 1'b0;
    emit_src    = SRC_FRAME;
    emit_base   = BASE_LINE;
    emit_len    = '0;
    if (in_kind_i) begin
      idle_d = idle_inc;
      if (capturing_q && (idle_inc > cap_tout_q)) begin
        capturing_d = 1'b0;
        cap_cnt_d   = '0;
      end
      if ((line_cnt_q != '0) && (idle_inc > line_tout_q)) begin
        emit       = 1'b1;
        emit_src   = SRC_LINE;
        emit_len   = LEN_W'(line_cnt_q);
        line_cnt_d = '0;
      end
    end else begin
      idle_d = '0;
      if (capturing_q) begin
        if (cap_cnt_q >= CAP_CW'(CAPTURE_BYTES)) begin
          capturing_d = 1'b0;
          cap_cnt_d   = '0;
        end else begin
          cap_we    = 1'b1;
          cap_wa    = cap_cnt_q[CAP_AW-1:0];
          cap_cnt_d = cap_cnt_q + 1'b1;
          if (cnt9 == 9'd1) len_d = in_rx_byte_i;
          if (cnt9 == 9'd2) b2_d = in_rx_byte_i;
          if (cnt9 == 9'd3) b3_d = in_rx_byte_i;
          if ((cnt9 >= 9'd2) && (cnt9 <= len9 + 9'd1)) begin
            sum_d = sum_q + in_rx_byte_i;
          end
          if ((ncnt9 == 9'(FIXED_FRAME_BYTES)) && is_tail &&
              ((len_q + b2_q) == b3_q)) begin
            emit        = 1'b1;
            emit_base   = BASE_FIXED;
            emit_len    = LEN_W'(2);
            capturing_d = 1'b0;
            cap_cnt_d   = '0;
          end else if ((ncnt9 == 9'(EMPTY_FRAME_BYTES)) && (len_q == '0)) begin
            if ((b2_q == '0) && is_tail) begin
              emit        = 1'b1;
              emit_empty  = 1'b1;
              capturing_d = 1'b0;
              cap_cnt_d   = '0;
            end
          end else if ((ncnt9 == 9'(FIXED_FRAME_BYTES)) && (len_q == 8'd1)) begin
            if (is_tail && (b2_q == b3_q)) begin
              emit        = 1'b1;
              emit_base   = BASE_VAR;
              emit_len    = LEN_W'(1);
              capturing_d = 1'b0;
              cap_cnt_d   = '0;
            end
          end else if (ncnt9 > 9'(FIXED_FRAME_BYTES)) begin
            if (len_q > DATA_W'(PAYLOAD_MAX)) begin
              capturing_d = 1'b0;
              cap_cnt_d   = '0;
            end else if (ncnt9 == len9 + 9'(FRAME_OVERHEAD)) begin
              if (is_tail && (sum_q == prev_q)) begin
                emit      = 1'b1;
                emit_base = BASE_VAR;
                emit_len  = len_q[LEN_W-1:0];
              end
              capturing_d = 1'b0;
              cap_cnt_d   = '0;
            end
          end
        end
      end else if (in_rx_byte_i == frame_head_q) begin
        cap_we      = 1'b1;
        cap_wa      = '0;
        cap_cnt_d   = CAP_CW'(1);
        capturing_d = 1'b1;
        sum_d       = '0;
      end else if ((in_rx_byte_i == CH_CR) || (in_rx_byte_i == CH_LF)) begin
        if (line_cnt_q != '0) begin
          emit       = 1'b1;
          emit_src   = SRC_LINE;
          emit_len   = LEN_W'(line_cnt_q);
          line_cnt_d = '0;
        end
      end else if (line_cnt_q < LINE_AW'(LINE_BYTES - 1)) begin
        line_we    = 1'b1;
        line_cnt_d = line_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      cap_cnt_q   <= '0;
      line_cnt_q  <= '0;
      idle_q      <= '0;
      src_q       <= SRC_FRAME;
      empty_q     <= 1'b0;
      base_q      <= BASE_LINE;
      blen_q      <= '0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.accept) begin
        capturing_q <= capturing_d;
        cap_cnt_q   <= cap_cnt_d;
        line_cnt_q  <= line_cnt_d;
        idle_q      <= idle_d;
        if (emit) begin
          src_q   <= emit_src;
          empty_q <= emit_empty;
          base_q  <= emit_base;
          blen_q  <= emit_len;
          idx_q   <= '0;
        end
      end else if (cmd_i.load) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      len_q  <= len_d;
      b2_q   <= b2_d;
      b3_q   <= b3_d;
      sum_q  <= sum_d;
      if (!in_kind_i) begin
        prev_q <= in_rx_byte_i;
      end
    end
  end

  assign cap_ra = CAP_AW'(base_q) + CAP_AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && cap_we) begin
      cap_mem[cap_wa] <= in_rx_byte_i;
    end
    cap_rdata_q <= cap_mem[cap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && line_we) begin
      line_mem[line_cnt_q] <= in_rx_byte_i;
    end
    line_rdata_q <= line_mem[LINE_AW'(idx_q)];
  end

  assign last_item = empty_q || ((idx_q + 1'b1) == blen_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_source_o       <= src_q;
      out_data_byte_o    <= empty_q ? '0 : (src_q ? line_rdata_q : cap_rdata_q);
      out_burst_length_o <= empty_q ? '0 : blen_q;
      out_empty_frame_o  <= empty_q;
      out_last_o         <= last_item;
    end
  end

  assign status_o.emit      = emit;
  assign status_o.last_item = last_item;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for hex_and_text_frame_receiver: drives random byte/tick streams,
// predicts frame payloads and text lines with a behavioral model and checks every transfer.
// Depends on rtl/hatfr_pkg.sv and rtl/hex_and_text_frame_receiver.sv.
`timescale 1ns / 1ps

module tb_top;
  import hatfr_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 140;
  localparam int TICK_RUN_MAX  = 300;

  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 8'hFF;

  typedef enum logic {KIND_BYTE = 1'b0, KIND_TICK = 1'b1} item_kind_e;
  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TAIL, FRAME_STALLED} frame_flaw_e;
  typedef enum int {END_CR, END_LF, END_TICKS, END_NONE} line_end_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [DATA_W-1:0] rx;
  } rx_item_t;

  typedef struct packed {
    logic              source;
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  burst_length;
    logic              empty_frame;
    logic              last_flag;
  } burst_item_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  in_kind_i    = 1'b0;
  logic [DATA_W-1:0]     in_rx_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  out_source_o;
  logic [DATA_W-1:0]     out_data_byte_o;
  logic [LEN_W-1:0]      out_burst_length_o;
  logic                  out_empty_frame_o;
  logic                  out_last_o;

  hex_and_text_frame_receiver i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_kind_i          (in_kind_i),
    .in_rx_byte_i       (in_rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_source_o       (out_source_o),
    .out_data_byte_o    (out_data_byte_o),
    .out_burst_length_o (out_burst_length_o),
    .out_empty_frame_o  (out_empty_frame_o),
    .out_last_o         (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  logic [DATA_W-1:0] head_r      = FRAME_HEAD_RST;
  logic [DATA_W-1:0] tail_r      = FRAME_TAIL_RST;
  logic [TICK_W-1:0] cap_tout_r  = CAPTURE_TOUT_RST;
  logic [TICK_W-1:0] line_tout_r = LINE_TOUT_RST;

  bit                capturing  = 1'b0;
  int unsigned       cap_cnt    = 0;
  logic [DATA_W-1:0] cap_mem [CAPTURE_BYTES];
  int unsigned       line_cnt   = 0;
  logic [DATA_W-1:0] line_mem [LINE_BYTES];
  logic [TICK_W-1:0] idle_ticks = '0;

  rx_item_t    rx_q [$];
  burst_item_t burst_q [$];
  rx_item_t    cur_item;
  int unsigned gen_count     = 0;
  int unsigned n_errors      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 52;

  function automatic void push_result(logic src, logic [DATA_W-1:0] d, int unsigned n,
                                      logic empty, logic last_flag);
    burst_item_t r;
    r.source       = src;
    r.data_byte    = d;
    r.burst_length = n[LEN_W-1:0];
    r.empty_frame  = empty;
    r.last_flag    = last_flag;
    burst_q.push_back(r);
  endfunction

  function automatic void flush_line();
    int unsigned n;
    n = line_cnt;
    for (int unsigned i = 0; i < n; i++) begin
      push_result(SRC_LINE, line_mem[i], n, 1'b0, i + 1 == n);
    end
    line_cnt = 0;
  endfunction

  function automatic void emit_capture(int unsigned first, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      push_result(SRC_FRAME, cap_mem[first + i], n, 1'b0, i + 1 == n);
    end
  endfunction

  function automatic void close_capture();
    capturing = 1'b0;
    cap_cnt   = 0;
  endfunction

  function automatic void capture_step(logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] plen;
    logic [DATA_W-1:0] acc;
    int unsigned       want;
    if (cap_cnt >= CAPTURE_BYTES) begin
      close_capture();
      return;
    end
    cap_mem[cap_cnt] = b;
    cap_cnt++;
    acc = cap_mem[1] + cap_mem[2];
    if (cap_cnt == FIXED_FRAME_BYTES && cap_mem[4] == tail_r && acc == cap_mem[3]) begin
      emit_capture(1, 2);
      close_capture();
      return;
    end
    plen = cap_mem[1];
    if (cap_cnt == EMPTY_FRAME_BYTES && plen == 0) begin
      if (cap_mem[2] == 0 && cap_mem[3] == tail_r) begin
        push_result(SRC_FRAME, '0, 0, 1'b1, 1'b1);
        close_capture();
      end
    end else if (cap_cnt == FIXED_FRAME_BYTES && plen == 1) begin
      if (cap_mem[4] == tail_r && cap_mem[2] == cap_mem[3]) begin
        emit_capture(2, 1);
        close_capture();
      end
    end else if (cap_cnt > FIXED_FRAME_BYTES) begin
      if (plen > PAYLOAD_MAX) begin
        close_capture();
      end else begin
        want = plen + FRAME_OVERHEAD;
        if (cap_cnt == want) begin
          if (cap_mem[want - 1] == tail_r) begin
            acc = '0;
            for (int unsigned i = 0; i < plen; i++) acc += cap_mem[2 + i];
            if (acc == cap_mem[want - 2]) emit_capture(2, 32'(plen));
          end
          close_capture();
        end
      end
    end
  endfunction

  function automatic void receive_item(rx_item_t it);
    if (it.kind == KIND_TICK) begin
      if (idle_ticks != '1) idle_ticks++;
      if (capturing && idle_ticks > cap_tout_r) close_capture();
      if (line_cnt > 0 && idle_ticks > line_tout_r) flush_line();
      return;
    end
    idle_ticks = '0;
    if (capturing) begin
      capture_step(it.rx);
    end else if (it.rx == head_r) begin
      cap_mem[0] = it.rx;
      cap_cnt    = 1;
      capturing  = 1'b1;
    end else if (it.rx == CH_CR || it.rx == CH_LF) begin
      if (line_cnt > 0) flush_line();
    end else if (line_cnt < LINE_BYTES - 1) begin
      line_mem[line_cnt] = it.rx;
      line_cnt++;
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRAME_HEAD:   head_r      = val[DATA_W-1:0];
      REG_FRAME_TAIL:   tail_r      = val[DATA_W-1:0];
      REG_CAPTURE_TOUT: cap_tout_r  = val[TICK_W-1:0];
      REG_LINE_TOUT:    line_tout_r = val[TICK_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : rx_driver
    bit taken;
    taken = rst_ni && in_valid_i && !in_stall_o;
    if (taken) receive_item(cur_item);
    @(negedge clk_i);
    if (!in_valid_i || taken) begin
      if (rx_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_item = rx_q.pop_front();
        in_valid_i   <= 1'b1;
        in_kind_i    <= cur_item.kind;
        in_rx_byte_i <= cur_item.rx;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    burst_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (burst_q.size() == 0) begin
        $error("unexpected result: source %0d data_byte %0d", out_source_o, out_data_byte_o);
        n_errors++;
      end else begin
        want = burst_q.pop_front();
        check_field("source", 32'(want.source), 32'(out_source_o));
        check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte_o));
        check_field("burst_length", 32'(want.burst_length), 32'(out_burst_length_o));
        check_field("empty_frame", 32'(want.empty_frame), 32'(out_empty_frame_o));
        check_field("last", 32'(want.last_flag), 32'(out_last_o));
      end
    end
    @(negedge clk_i);
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drain(input int unsigned settle);
    do @(posedge clk_i); while (rx_q.size() != 0 || in_valid_i || burst_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [DATA_W-1:0] b);
    rx_item_t it;
    it.kind = KIND_BYTE;
    it.rx   = b;
    rx_q.push_back(it);
    gen_count++;
  endtask

  task automatic push_ticks(input int unsigned n);
    rx_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.kind = KIND_TICK;
      it.rx   = DATA_W'($urandom_range(0, 255));
      rx_q.push_back(it);
      gen_count++;
    end
  endtask

  function automatic logic [DATA_W-1:0] spoil(logic [DATA_W-1:0] b);
    return b ^ DATA_W'($urandom_range(1, 255));
  endfunction

  function automatic frame_flaw_e pick_flaw();
    if ($urandom_range(0, 3) != 0) return FRAME_GOOD;
    if ($urandom_range(0, 1) != 0) return FRAME_BAD_SUM;
    return FRAME_BAD_TAIL;
  endfunction

  task automatic push_fixed(input frame_flaw_e flaw);
    logic [DATA_W-1:0] d0, d1, s;
    d0 = DATA_W'($urandom_range(0, 255));
    d1 = DATA_W'($urandom_range(0, 255));
    s  = d0 + d1;
    push_byte(head_r);
    push_byte(d0);
    push_byte(d1);
    push_byte(flaw == FRAME_BAD_SUM ? spoil(s) : s);
    push_byte(flaw == FRAME_BAD_TAIL ? spoil(tail_r) : tail_r);
  endtask

  task automatic push_var(input int unsigned len, input frame_flaw_e flaw);
    logic [DATA_W-1:0] d, acc;
    acc = '0;
    push_byte(head_r);
    push_byte(DATA_W'(len));
    if (flaw == FRAME_STALLED) push_ticks(cap_tout_r < TICK_RUN_MAX ? cap_tout_r + 1 : 3);
    for (int unsigned i = 0; i < len; i++) begin
      d = DATA_W'($urandom_range(0, 255));
      acc += d;
      push_byte(d);
    end
    push_byte(flaw == FRAME_BAD_SUM ? spoil(acc) : acc);
    push_byte(flaw == FRAME_BAD_TAIL ? spoil(tail_r) : tail_r);
  endtask

  task automatic push_oversized();
    push_byte(head_r);
    push_byte(DATA_W'($urandom_range(PAYLOAD_MAX + 1, 255)));
    repeat ($urandom_range(1, 6)) push_byte(DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic push_overflow();
    push_var($urandom_range(0, 1), FRAME_BAD_TAIL);
    repeat (CAPTURE_BYTES - 2) push_byte(DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic push_line(input int unsigned n, input line_end_e how);
    logic [DATA_W-1:0] c;
    for (int unsigned i = 0; i < n; i++) begin
      do c = DATA_W'($urandom_range(0, 255)); while (c == head_r || c == CH_CR || c == CH_LF);
      push_byte(c);
    end
    case (how)
      END_CR:    push_byte(CH_CR);
      END_LF:    push_byte(CH_LF);
      END_TICKS: begin
        if (line_tout_r < TICK_RUN_MAX) push_ticks(line_tout_r + 1);
        else push_byte(CH_LF);
      end
      default: ;
    endcase
  endtask

  task automatic add_random(input int unsigned target);
    int unsigned stop, n;
    stop = gen_count + target;
    while (gen_count < stop) begin
      case ($urandom_range(0, 15))
        0, 1, 2:  push_fixed(pick_flaw());
        3:        push_var(0, pick_flaw());
        4:        push_var(1, pick_flaw());
        5, 6, 7: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, PAYLOAD_MAX)
                                          : $urandom_range(2, 8);
          push_var(n, pick_flaw());
        end
        8:        push_oversized();
        9:        push_overflow();
        10, 11: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
          push_line(n, line_end_e'($urandom_range(0, 3)));
        end
        12: begin
          n = $urandom_range(1, 4);
          if ($urandom_range(0, 3) == 0) n = (line_tout_r < TICK_RUN_MAX) ? line_tout_r + 2 : 5;
          push_ticks(n);
        end
        13:       repeat ($urandom_range(1, 4)) push_byte(DATA_W'($urandom_range(0, 255)));
        14:       push_var($urandom_range(0, 6), FRAME_STALLED);
        default:  push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_byte(head_r); push_byte(8'h12); push_byte(8'h34); push_byte(8'h46); push_byte(tail_r);
    push_byte(head_r); push_byte(8'h00); push_byte(8'h00); push_byte(tail_r);
    push_byte(head_r); push_byte(8'h01); push_byte(8'hFF); push_byte(8'hFF); push_byte(tail_r);
    push_byte(head_r); push_byte(8'h02); push_byte(8'h80); push_byte(8'h80);
    push_byte(8'h00); push_byte(tail_r);
    push_byte(8'h00); push_byte(8'hFF); push_byte(CH_CR);
    push_byte(CH_LF);
    push_ticks(1);
    wait_drain(SETTLE_CYCLES);

    write_reg(REG_FRAME_HEAD, 16'hFF00);
    write_reg(REG_FRAME_TAIL, 16'h00FF);
    write_reg(REG_CAPTURE_TOUT, 16'd0);
    write_reg(REG_LINE_TOUT, 16'd3);
    write_reg(REG_NONE_LO, 16'hFFFF);
    write_reg(REG_NONE_HI, 16'h1234);
    push_line(70, END_CR);
    push_var(PAYLOAD_MAX, FRAME_GOOD);
    push_overflow();
    add_random(65);
    wait_drain(SETTLE_CYCLES);

    send_idle_pct = 52;
    recv_idle_pct = 27;
    write_reg(REG_FRAME_HEAD, 16'h00FF);
    write_reg(REG_FRAME_TAIL, 16'hAB00);
    write_reg(REG_CAPTURE_TOUT, 16'hFFFF);
    write_reg(REG_LINE_TOUT, 16'hFFFF);
    add_random(35);
    wait_drain(SETTLE_CYCLES);
    add_random(35);
    wait_drain(SETTLE_CYCLES);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_FRAME_HEAD, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    write_reg(REG_FRAME_TAIL, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    write_reg(REG_CAPTURE_TOUT, CFG_DATA_W'($urandom_range(1, 12)));
    write_reg(REG_LINE_TOUT, CFG_DATA_W'($urandom_range(1, 20)));
    add_random(65);
    wait_drain(TAIL_CYCLES);

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
